// ----- rtl/core/drld_pkg.sv -----
package drld_pkg;

    localparam int MAX_FIELD_BYTES = 8;
    localparam logic [3:0] LOW_NIBBLE = 4'h0F;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic [1:0] CAUSE_ZERO_HDR  = 2'd0;
    localparam logic [1:0] CAUSE_STREAM_END = 2'd1;
    localparam logic [1:0] CAUSE_RUN_LIMIT  = 2'd2;
    localparam logic [1:0] CAUSE_TRUNCATED  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] run_cluster;
        logic [31:0] run_size;
        logic [7:0]  run_index;
        logic [7:0]  run_count;
        logic [1:0]  end_cause;
        logic        final_res;
    } out_item_t;

    // One entry between front and back: an optional run, then an optional end item.
    typedef struct packed {
        logic        clear;
        logic        has_run;
        logic        has_end;
        logic [31:0] delta;
        logic [31:0] length;
        logic [7:0]  index;
        logic [7:0]  count;
        logic [1:0]  cause;
    } cmd_t;

    // Sign-extend the kept delta bytes; only the low 32 bits of the cluster are ever seen,
    // so kept counts of four and up leave the low word unchanged.
    function automatic logic [31:0] sext_delta(input logic [31:0] acc, input logic [3:0] total);
        logic [3:0] kept;
        logic [31:0] res;
        kept = (total < 4'(MAX_FIELD_BYTES)) ? total : 4'(MAX_FIELD_BYTES);
        res = acc;
        case (kept)
            4'd1:    res = {{24{acc[7]}}, acc[7:0]};
            4'd2:    res = {{16{acc[15]}}, acc[15:0]};
            4'd3:    res = {{8{acc[23]}}, acc[23:0]};
            default: res = acc;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/core/drld_front.sv -----
module drld_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  drld_pkg::in_item_t  in_data,
    input  logic                q_full,
    output logic                push,
    output drld_pkg::cmd_t      cmd
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_DELTA  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [7:0]  run_limit_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [3:0]  del_left_reg, del_left_next;
    logic [3:0]  del_total_reg, del_total_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] len_acc_reg, len_acc_next;
    logic [31:0] del_acc_reg, del_acc_next;
    logic [7:0]  runs_reg, runs_next;
    logic        pend_reg, pend_next;

    logic        in_fire;
    logic        fin;
    logic [1:0]  cur_phase;
    logic [7:0]  cur_runs;
    logic [7:0]  runs_inc;
    logic [3:0]  pos_inc;
    logic [3:0]  len_dec;
    logic [3:0]  del_dec;
    logic [31:0] take_val;
    logic [7:0]  b;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;
    assign b        = in_data.data_byte;

    assign cur_phase = in_data.first ? PH_HEADER : phase_reg;
    assign cur_runs  = in_data.first ? 8'd0 : runs_reg;
    assign runs_inc  = (cur_runs == 8'hFF) ? cur_runs : cur_runs + 8'd1;
    assign pos_inc   = (pos_reg == 4'hF) ? pos_reg : pos_reg + 4'd1;
    assign len_dec   = len_left_reg - 4'd1;
    assign del_dec   = del_left_reg - 4'd1;

    // bytes past the kept field width, or above the low word, are dropped
    assign take_val = (pos_reg < 4'd4 && pos_reg < 4'(drld_pkg::MAX_FIELD_BYTES))
                    ? ({24'd0, b} << {pos_reg[1:0], 3'b000}) : 32'd0;

    always_comb
    begin
        phase_next     = cur_phase;
        runs_next      = cur_runs;
        len_left_next  = len_left_reg;
        del_left_next  = del_left_reg;
        del_total_next = del_total_reg;
        pos_next       = pos_reg;
        len_acc_next   = len_acc_reg;
        del_acc_next   = del_acc_reg;
        fin            = 1'b0;
        cmd            = '0;
        cmd.clear      = pend_reg || in_data.first;

        case (cur_phase)
            PH_HEADER:
            begin
                if (cur_runs >= run_limit_reg)
                begin
                    cmd.has_end = 1'b1;
                    cmd.cause   = drld_pkg::CAUSE_RUN_LIMIT;
                    cmd.count   = cur_runs;
                    phase_next  = PH_DONE;
                end
                else if (b == 8'd0)
                begin
                    cmd.has_end = 1'b1;
                    cmd.cause   = drld_pkg::CAUSE_ZERO_HDR;
                    cmd.count   = cur_runs;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    len_left_next  = b[3:0] & drld_pkg::LOW_NIBBLE;
                    del_left_next  = b[7:4];
                    del_total_next = b[7:4];
                    pos_next       = 4'd0;
                    len_acc_next   = 32'd0;
                    del_acc_next   = 32'd0;
                    phase_next     = (b[3:0] != 4'd0) ? PH_LENGTH : PH_DELTA;
                    if (in_data.last)
                    begin
                        cmd.has_end = 1'b1;
                        cmd.cause   = drld_pkg::CAUSE_TRUNCATED;
                        cmd.count   = cur_runs;
                        phase_next  = PH_DONE;
                    end
                end
            end
            PH_LENGTH:
            begin
                len_acc_next  = len_acc_reg | take_val;
                pos_next      = pos_inc;
                len_left_next = len_dec;
                if (len_dec == 4'd0 && del_left_reg == 4'd0)
                begin
                    pos_next = 4'd0;
                    fin      = 1'b1;
                end
                else
                begin
                    if (len_dec == 4'd0)
                    begin
                        pos_next   = 4'd0;
                        phase_next = PH_DELTA;
                    end
                    if (in_data.last)
                    begin
                        cmd.has_end = 1'b1;
                        cmd.cause   = drld_pkg::CAUSE_TRUNCATED;
                        cmd.count   = cur_runs;
                        phase_next  = PH_DONE;
                    end
                end
            end
            PH_DELTA:
            begin
                del_acc_next  = del_acc_reg | take_val;
                pos_next      = pos_inc;
                del_left_next = del_dec;
                if (del_dec == 4'd0)
                begin
                    fin = 1'b1;
                end
                else if (in_data.last)
                begin
                    cmd.has_end = 1'b1;
                    cmd.cause   = drld_pkg::CAUSE_TRUNCATED;
                    cmd.count   = cur_runs;
                    phase_next  = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            cmd.has_run = 1'b1;
            cmd.delta   = drld_pkg::sext_delta(del_acc_next, del_total_reg);
            cmd.length  = len_acc_next;
            cmd.index   = cur_runs;
            runs_next   = runs_inc;
            phase_next  = PH_HEADER;
            pos_next    = 4'd0;
            // stream end wins over the run limit
            if (in_data.last)
            begin
                cmd.has_end = 1'b1;
                cmd.cause   = drld_pkg::CAUSE_STREAM_END;
                cmd.count   = runs_inc;
                phase_next  = PH_DONE;
            end
            else if (runs_inc >= run_limit_reg)
            begin
                cmd.has_end = 1'b1;
                cmd.cause   = drld_pkg::CAUSE_RUN_LIMIT;
                cmd.count   = runs_inc;
                phase_next  = PH_DONE;
            end
        end

        push      = in_fire && (cmd.has_run || cmd.has_end);
        pend_next = (cmd.has_run || cmd.has_end) ? 1'b0 : cmd.clear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_limit_reg <= 8'd4;
            phase_reg     <= PH_HEADER;
            len_left_reg  <= 4'd0;
            del_left_reg  <= 4'd0;
            del_total_reg <= 4'd0;
            pos_reg       <= 4'd0;
            runs_reg      <= 8'd0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                run_limit_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                len_left_reg  <= len_left_next;
                del_left_reg  <= del_left_next;
                del_total_reg <= del_total_next;
                pos_reg       <= pos_next;
                runs_reg      <= runs_next;
                pend_reg      <= pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            len_acc_reg <= len_acc_next;
            del_acc_reg <= del_acc_next;
        end
    end

endmodule

// ----- rtl/core/drld_queue.sv -----
module drld_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  drld_pkg::cmd_t  push_data,
    input  logic            pop,
    output drld_pkg::cmd_t  head,
    output logic            empty,
    output logic            full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    drld_pkg::cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty = (count_reg == CNT_W'(0));
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/drld_back.sv -----
module drld_back (
    input  logic                clk,
    input  logic                rst_n,
    input  drld_pkg::cmd_t      head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output drld_pkg::out_item_t out_data
);

    logic                out_valid_reg;
    drld_pkg::out_item_t out_data_reg, out_data_next;
    logic                step_reg;
    logic [31:0]         cluster_reg;

    logic        out_free;
    logic        go;
    logic        do_run;
    logic [31:0] base;
    logic [31:0] sum;

    assign out_free = !out_valid_reg || out_ready;
    assign go       = out_free && !empty;
    assign do_run   = head.has_run && !step_reg;
    assign base     = head.clear ? 32'd0 : cluster_reg;
    assign sum      = base + head.delta;
    // an entry with a run and an end stays at the head for a second transfer
    assign pop      = go && !(do_run && head.has_end);

    always_comb
    begin
        out_data_next = '0;
        if (do_run)
        begin
            out_data_next.kind        = drld_pkg::KIND_RUN;
            out_data_next.run_cluster = sum;
            out_data_next.run_size    = head.length;
            out_data_next.run_index   = head.index;
            out_data_next.final_res   = !head.has_end;
        end
        else
        begin
            out_data_next.kind      = drld_pkg::KIND_END;
            out_data_next.run_count = head.count;
            out_data_next.end_cause = head.cause;
            out_data_next.final_res = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= 1'b0;
            cluster_reg   <= 32'd0;
        end
        else
        begin
            if (go)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= do_run && head.has_end;
                if (!step_reg)
                begin
                    cluster_reg <= do_run ? sum : base;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/core/data_run_list_decoder_top.sv -----
// A result is written into the command queue when its byte transfers, then enters the output
// register from the queue head when the output is free; a second result from one entry follows.
// Throughput: one byte per cycle unless the queue is full; a byte that finishes a run and also ends
// decoding yields two results, and the output moves one result per cycle while out_ready is high.
// The command queue (QUEUE_DEPTH entries) lets bytes keep flowing while results stall.
// Reset: the run limit returns to 4, decoding restarts expecting a header, queue and output empty.
module data_run_list_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  drld_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output drld_pkg::out_item_t out_data
);

    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    logic           q_full;
    drld_pkg::cmd_t q_in;
    drld_pkg::cmd_t q_head;

    drld_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .q_full      (q_full),
        .push        (q_push),
        .cmd         (q_in)
    );

    drld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    drld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTH
    // a non-final transfer is always a run followed at once by its end item
    a_end_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.final_res
        |=> out_valid && out_data.kind == drld_pkg::KIND_END)
        else $error("end item did not follow a non-final run");

    a_run_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == drld_pkg::KIND_RUN
        |-> out_data.end_cause == drld_pkg::CAUSE_ZERO_HDR && out_data.run_count == 8'd0)
        else $error("run item carries end fields");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("command pushed into full queue");
`endif

endmodule
